// File: src/scd_pkg.sv
// shared constants, types and keymap roms for the scancode decoder
package scd_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int CODE_W      = $clog2(TABLE_DEPTH);

  localparam logic [7:0] BREAK_MASK   = 8'h80;
  localparam logic [7:0] CODE_LSHIFT  = 8'h2A;
  localparam logic [7:0] CODE_RSHIFT  = 8'h36;
  localparam logic [7:0] LIMIT_RESET  = 8'd90;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // one input beat as held in the input stage
  typedef struct packed {
    logic       op;
    logic [7:0] scan_byte;
  } scd_item_t;

  // us layout, unshifted
  function automatic logic [7:0] plain_key(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    case (code)
      7'd1:  c = 8'h1B;  7'd2:  c = 8'h31;  7'd3:  c = 8'h32;  7'd4:  c = 8'h33;
      7'd5:  c = 8'h34;  7'd6:  c = 8'h35;  7'd7:  c = 8'h36;  7'd8:  c = 8'h37;
      7'd9:  c = 8'h38;  7'd10: c = 8'h39;  7'd11: c = 8'h30;  7'd12: c = 8'h2D;
      7'd13: c = 8'h3D;  7'd14: c = 8'h08;  7'd15: c = 8'h09;  7'd16: c = 8'h71;
      7'd17: c = 8'h77;  7'd18: c = 8'h65;  7'd19: c = 8'h72;  7'd20: c = 8'h74;
      7'd21: c = 8'h79;  7'd22: c = 8'h75;  7'd23: c = 8'h69;  7'd24: c = 8'h6F;
      7'd25: c = 8'h70;  7'd26: c = 8'h5B;  7'd27: c = 8'h5D;  7'd28: c = 8'h0A;
      7'd30: c = 8'h61;  7'd31: c = 8'h73;  7'd32: c = 8'h64;  7'd33: c = 8'h66;
      7'd34: c = 8'h67;  7'd35: c = 8'h68;  7'd36: c = 8'h6A;  7'd37: c = 8'h6B;
      7'd38: c = 8'h6C;  7'd39: c = 8'h3B;  7'd40: c = 8'h27;  7'd41: c = 8'h60;
      7'd43: c = 8'h5C;  7'd44: c = 8'h7A;  7'd45: c = 8'h78;  7'd46: c = 8'h63;
      7'd47: c = 8'h76;  7'd48: c = 8'h62;  7'd49: c = 8'h6E;  7'd50: c = 8'h6D;
      7'd51: c = 8'h2C;  7'd52: c = 8'h2E;  7'd53: c = 8'h2F;  7'd55: c = 8'h2A;
      7'd57: c = 8'h20;  7'd74: c = 8'h2D;  7'd78: c = 8'h2B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // us layout, with shift held
  function automatic logic [7:0] shifted_key(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    case (code)
      7'd1:  c = 8'h1B;  7'd2:  c = 8'h21;  7'd3:  c = 8'h40;  7'd4:  c = 8'h23;
      7'd5:  c = 8'h24;  7'd6:  c = 8'h25;  7'd7:  c = 8'h5E;  7'd8:  c = 8'h26;
      7'd9:  c = 8'h2A;  7'd10: c = 8'h28;  7'd11: c = 8'h29;  7'd12: c = 8'h5F;
      7'd13: c = 8'h2B;  7'd14: c = 8'h08;  7'd15: c = 8'h09;  7'd16: c = 8'h51;
      7'd17: c = 8'h57;  7'd18: c = 8'h45;  7'd19: c = 8'h52;  7'd20: c = 8'h54;
      7'd21: c = 8'h59;  7'd22: c = 8'h55;  7'd23: c = 8'h49;  7'd24: c = 8'h4F;
      7'd25: c = 8'h50;  7'd26: c = 8'h7B;  7'd27: c = 8'h7D;  7'd28: c = 8'h0A;
      7'd30: c = 8'h41;  7'd31: c = 8'h53;  7'd32: c = 8'h44;  7'd33: c = 8'h46;
      7'd34: c = 8'h47;  7'd35: c = 8'h48;  7'd36: c = 8'h4A;  7'd37: c = 8'h4B;
      7'd38: c = 8'h4C;  7'd39: c = 8'h3A;  7'd40: c = 8'h22;  7'd41: c = 8'h7E;
      7'd43: c = 8'h7C;  7'd44: c = 8'h5A;  7'd45: c = 8'h58;  7'd46: c = 8'h43;
      7'd47: c = 8'h56;  7'd48: c = 8'h42;  7'd49: c = 8'h4E;  7'd50: c = 8'h4D;
      7'd51: c = 8'h3C;  7'd52: c = 8'h3E;  7'd53: c = 8'h3F;  7'd55: c = 8'h2A;
      7'd57: c = 8'h20;  7'd74: c = 8'h2D;  7'd78: c = 8'h2B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: src/scd_core.sv
// shift tracking, keymap lookup and held key state
module scd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              fire,
  input  scd_pkg::scd_item_t item,
  output logic [7:0]        key_char
);

  logic       lshift_r, lshift_nxt;
  logic       rshift_r, rshift_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] limit_r;
  logic [6:0] released;
  logic [scd_pkg::CODE_W-1:0] code;
  logic [7:0] lookup;

  assign released = item.scan_byte[6:0];
  assign code     = item.scan_byte[scd_pkg::CODE_W-1:0];
  assign key_char = held_r;

  // rom lookup picks the shifted table when either shift is down
  assign lookup = (lshift_r || rshift_r) ? scd_pkg::shifted_key(code)
                                         : scd_pkg::plain_key(code);

  // next state for one beat
  always_comb begin
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    held_nxt   = held_r;
    if (fire) begin
      if (item.op == scd_pkg::OP_READ) begin
        held_nxt = 8'h00;
      end else if ((item.scan_byte & scd_pkg::BREAK_MASK) != 8'h00) begin
        if (released == scd_pkg::CODE_LSHIFT[6:0]) begin
          lshift_nxt = 1'b0;
        end else if (released == scd_pkg::CODE_RSHIFT[6:0]) begin
          rshift_nxt = 1'b0;
        end
      end else if (item.scan_byte == scd_pkg::CODE_LSHIFT) begin
        lshift_nxt = 1'b1;
      end else if (item.scan_byte == scd_pkg::CODE_RSHIFT) begin
        rshift_nxt = 1'b1;
      end else if (item.scan_byte != 8'h00 && item.scan_byte < limit_r) begin
        held_nxt = lookup;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lshift_r <= 1'b0;
      rshift_r <= 1'b0;
      held_r   <= 8'h00;
      limit_r  <= scd_pkg::LIMIT_RESET;
    end else begin
      lshift_r <= lshift_nxt;
      rshift_r <= rshift_nxt;
      held_r   <= held_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

`ifndef SYNTH
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.op == scd_pkg::OP_READ |=> held_r == 8'h00)
    else $error("held key not cleared by read");
  a_lshift_make: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.op == scd_pkg::OP_SCAN && item.scan_byte == scd_pkg::CODE_LSHIFT
    |=> lshift_r)
    else $error("left shift make not tracked");
  a_lshift_break: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.op == scd_pkg::OP_SCAN
    && item.scan_byte == (scd_pkg::CODE_LSHIFT | scd_pkg::BREAK_MASK) |=> !lshift_r)
    else $error("left shift break not tracked");
  a_shift_keeps_key: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.op == scd_pkg::OP_SCAN && item.scan_byte == scd_pkg::CODE_RSHIFT
    |=> $stable(held_r))
    else $error("shift make changed held key");
`endif

endmodule

// File: src/scancode_to_ascii_decoder.sv
// top level: input stage, decoder core and result register
// a read beat passes the input stage and then the result register before its result is on out_valid
// throughput: one beat per cycle, limited only by the result register
// scan beats produce no result and never wait on the output side
// reset (rst_n low, synchronous): both stages empty, shifts released,
// held key zero, keymap limit back to 90
module scancode_to_ascii_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_key_char
);

  logic              s1_valid_r;
  scd_pkg::scd_item_t s1_item_r;
  logic              s1_go;
  logic              fire;
  logic              out_valid_r;
  logic [7:0]        out_key_r;
  logic [7:0]        held_key;

  // a read beat waits only when the result register is full and stalled
  assign s1_go    = !(s1_item_r.op == scd_pkg::OP_READ && out_valid_r && out_stall);
  assign fire     = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r.op        <= in_op;
      s1_item_r.scan_byte <= in_scan_byte;
    end
  end

  scd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (s1_item_r),
    .key_char  (held_key)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && s1_item_r.op == scd_pkg::OP_READ) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_item_r.op == scd_pkg::OP_READ) begin
      out_key_r <= held_key;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_char = out_key_r;

endmodule

// File: test/scd_checker.sv
// checker for the scancode decoder: shift and held-key prediction, result comparison
module scd_checker
  import scd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_scan_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_key_char,
  output int         mismatches,
  output int         pending,
  output int         reads_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // us layout, codes 0 to 89, code 0 first; everything above reads as zero
  localparam int US_KEYS = 90;
  localparam logic [0:US_KEYS-1][7:0] US_PLAIN = {
    80'h001B3132333435363738, 80'h39302D3D080971776572, 80'h747975696F705B5D0A00,
    80'h6173646667686A6B6C3B, 80'h2760005C7A786376626E, 80'h6D2C2E2F002A00200000,
    80'h00000000000000000000, 80'h000000002D0000002B00, 80'h00000000000000000000
  };
  localparam logic [0:US_KEYS-1][7:0] US_SHIFT = {
    80'h001B21402324255E262A, 80'h28295F2B080951574552, 80'h545955494F507B7D0A00,
    80'h4153444647484A4B4C3A, 80'h227E007C5A584356424E, 80'h4D3C3E3F002A00200000,
    80'h00000000000000000000, 80'h000000002D0000002B00, 80'h00000000000000000000
  };

  logic [7:0] limit_q;
  logic       left_held;
  logic       right_held;
  logic [7:0] held_char;
  logic [7:0] want_char;
  logic [7:0] char_q[$];

  always @(posedge clk) begin
    if (!rst_n) begin
      limit_q       = LIMIT_RESET;
      left_held     = 1'b0;
      right_held    = 1'b0;
      held_char     = 8'h00;
      mismatches    = 0;
      reads_checked = 0;
      char_q.delete();
    end else begin
      // register write, only ever issued while the block is idle
      if (cfg_we) begin
        limit_q = cfg_wdata;
      end

      // result beat against the oldest expected character
      if (out_valid && !out_stall) begin
        if (char_q.size() == 0) begin
          $error("key_char: no result expected, actual %02h", out_key_char);
          mismatches++;
        end else begin
          want_char = char_q.pop_front();
          reads_checked++;
          if (out_key_char !== want_char) begin
            $error("key_char: expected %02h, actual %02h", want_char, out_key_char);
            mismatches++;
          end
        end
      end

      // input beat: read hands out and clears the held key, scan updates state
      if (in_valid && !in_stall) begin
        if (in_op == OP_READ) begin
          char_q.push_back(held_char);
          held_char = 8'h00;
        end else if ((in_scan_byte & BREAK_MASK) != 8'h00) begin
          if ((in_scan_byte & ~BREAK_MASK) == CODE_LSHIFT) begin
            left_held = 1'b0;
          end else if ((in_scan_byte & ~BREAK_MASK) == CODE_RSHIFT) begin
            right_held = 1'b0;
          end
        end else if (in_scan_byte == CODE_LSHIFT) begin
          left_held = 1'b1;
        end else if (in_scan_byte == CODE_RSHIFT) begin
          right_held = 1'b1;
        end else if (in_scan_byte != 8'h00 && in_scan_byte < limit_q) begin
          if (in_scan_byte >= US_KEYS) begin
            held_char = 8'h00;
          end else if (left_held || right_held) begin
            held_char = US_SHIFT[in_scan_byte];
          end else begin
            held_char = US_PLAIN[in_scan_byte];
          end
        end
      end
    end
    pending = char_q.size();
  end

endmodule

// File: test/tb.sv
// testbench top for the scancode decoder: stimulus, clock, reset and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 150;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       cfg_we       = 1'b0;
  logic [7:0] cfg_wdata    = 8'h00;
  logic       in_valid     = 1'b0;
  logic       in_op        = OP_SCAN;
  logic [7:0] in_scan_byte = 8'h00;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_key_char;

  int         mismatches;
  int         pending;
  int         reads_checked;
  int         cycles       = 0;
  int         beats_sent   = 0;
  int         limit_writes = 0;
  bit         steady       = 1'b0;
  int         p;
  int         i;
  logic [7:0] phase_limit;
  logic       rand_op;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  scancode_to_ascii_decoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_scan_byte (in_scan_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_char (out_key_char)
  );

  scd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_scan_byte  (in_scan_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_key_char  (out_key_char),
    .mismatches    (mismatches),
    .pending       (pending),
    .reads_checked (reads_checked)
  );

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side stalls now and then, never during the steady stretch
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 6);
  end

  // one input beat, with an occasional gap in front of it
  task automatic send_beat(input logic op, input logic [7:0] scan);
    if (!steady && $urandom_range(0, 99) < 3) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_scan_byte <= scan;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // hold the sender until every read has been answered and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_writes++;
  endtask

  // mostly real key traffic: shift presses, make codes, some noise
  function automatic logic [7:0] pick_scan();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      case ($urandom_range(0, 3))
        0:       return CODE_LSHIFT;
        1:       return CODE_RSHIFT;
        2:       return CODE_LSHIFT | BREAK_MASK;
        default: return CODE_RSHIFT | BREAK_MASK;
      endcase
    end
    if (r < 60) return 8'($urandom_range(1, 89));
    if (r < 72) return 8'($urandom_range(1, 127));
    if (r < 82) return 8'($urandom_range(0, 255)) | BREAK_MASK;
    if (r < 88) return 8'hE0;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty read, plain and shifted lookups, both shifts, ignored codes
    send_beat(OP_READ, 8'hFF);
    send_beat(OP_SCAN, 8'h1E);
    send_beat(OP_READ, 8'h00);
    send_beat(OP_SCAN, CODE_LSHIFT);
    send_beat(OP_SCAN, 8'h1E);
    send_beat(OP_READ, 8'h55);
    send_beat(OP_SCAN, 8'h10);
    send_beat(OP_SCAN, 8'h00);
    send_beat(OP_READ, 8'hAA);
    send_beat(OP_SCAN, CODE_LSHIFT | BREAK_MASK);
    send_beat(OP_SCAN, CODE_RSHIFT);
    send_beat(OP_SCAN, 8'h02);
    send_beat(OP_SCAN, CODE_LSHIFT);
    send_beat(OP_SCAN, CODE_RSHIFT | BREAK_MASK);
    send_beat(OP_SCAN, 8'h35);
    send_beat(OP_SCAN, 8'hE0);
    send_beat(OP_SCAN, 8'h9E);
    send_beat(OP_READ, 8'h01);
    send_beat(OP_SCAN, CODE_LSHIFT | BREAK_MASK);
    send_beat(OP_SCAN, 8'h4E);
    send_beat(OP_SCAN, 8'h5A);
    send_beat(OP_SCAN, 8'h7F);
    send_beat(OP_SCAN, 8'hFF);
    send_beat(OP_READ, 8'h80);
    send_beat(OP_SCAN, 8'h39);
    send_beat(OP_SCAN, 8'h59);
    send_beat(OP_READ, 8'h7E);

    // random phases, each under its own keymap limit
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_limit = 8'd255;
        1:       phase_limit = 8'd0;
        2:       phase_limit = 8'd128;
        3:       phase_limit = 8'd1;
        4:       phase_limit = 8'($urandom_range(2, 254));
        default: phase_limit = LIMIT_RESET;
      endcase
      write_limit(phase_limit);
      for (i = 0; i < PHASE_BEATS; i++) begin
        steady  = (p == 2) && (i >= 20) && (i < 140);
        rand_op = ($urandom_range(0, 99) < 25) ? OP_READ : OP_SCAN;
        if (rand_op == OP_READ) begin
          send_beat(OP_READ, 8'($urandom_range(0, 255)));
        end else begin
          send_beat(OP_SCAN, pick_scan());
        end
      end
    end
    steady = 1'b0;

    // wait out the last reads
    drain();
    repeat (4) @(posedge clk);

    $display("run: %0d beats, %0d reads compared, %0d limit writes", beats_sent,
             reads_checked, limit_writes);
    $display("run: limits 90, 255, 0, 128, 1, random; shifts, breaks and prefixes mixed in");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/scd_pkg.sv
src/scd_core.sv
src/scancode_to_ascii_decoder.sv
test/scd_checker.sv
test/tb.sv
